// ===== hdl/scmpm_pkg.sv =====
// Package for the slope-matched crossing pitch meter.
// Holds field widths, register indexes, reset values and shared structs.
// No dependencies.
package scmpm_pkg;

    localparam int SAMPLE_BITS = 8;
    localparam int TIME_BITS   = 32;
    localparam int MISS_BITS   = 10;
    localparam int RATE_BITS   = 27;
    localparam int FREQ_BITS   = 31;
    localparam int CFG_BITS    = 27;
    localparam int CFG_IDX_BITS = 2;
    localparam int FRAC_BITS_DEF = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIDPOINT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MISS_LIM  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TICK_RATE = 2'd3;

    localparam logic [SAMPLE_BITS-1:0] MIDPOINT_RST  = 8'd127;
    localparam logic [SAMPLE_BITS-1:0] TOLERANCE_RST = 8'd3;
    localparam logic [MISS_BITS-1:0]   MISS_LIM_RST  = 10'd300;
    localparam logic [RATE_BITS-1:0]   TICK_RATE_RST = 27'd16000000;

    localparam logic [MISS_BITS-1:0] MISS_MAX = 10'd1023;
    localparam logic [FREQ_BITS-1:0] FREQ_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] midpoint_level;
        logic [SAMPLE_BITS-1:0] slope_tolerance;
        logic [MISS_BITS-1:0]   miss_limit;
        logic [RATE_BITS-1:0]   tick_rate;
    } cfg_t;

    typedef struct packed {
        logic                 push;
        logic [TIME_BITS-1:0] period;
    } queue_wr_t;

    typedef struct packed {
        logic                 valid;
        logic [TIME_BITS-1:0] period;
    } queue_rd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_LOAD
    } back_state_t;

endpackage

// ===== hdl/scmpm_front.sv =====
// Front end: crossing detection, slope matching and period start/stop.
// Pushes measured periods into the queue. Depends on scmpm_pkg.
module scmpm_front
    import scmpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [TIME_BITS-1:0]   timestamp,
    input  logic                   q_full,
    output queue_wr_t              q_wr
);

    logic [SAMPLE_BITS-1:0] last_sample_reg, last_sample_next;
    logic [SAMPLE_BITS-1:0] peak_slope_reg, peak_slope_next;
    logic [MISS_BITS-1:0]   miss_count_reg, miss_count_next;
    logic                   measuring_reg, measuring_next;
    logic [TIME_BITS-1:0]   start_time_reg, start_time_next;

    logic                   accept;
    logic                   crossing;
    logic                   match;
    logic [SAMPLE_BITS-1:0] slope;
    logic [SAMPLE_BITS-1:0] diff;
    logic [MISS_BITS-1:0]   miss_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign crossing = (last_sample_reg < cfg.midpoint_level) && (sample >= cfg.midpoint_level);
    assign slope    = sample - last_sample_reg;
    assign diff     = (slope >= peak_slope_reg) ? (slope - peak_slope_reg)
                                                : (peak_slope_reg - slope);
    assign match    = diff < cfg.slope_tolerance;
    assign miss_inc = (miss_count_reg != MISS_MAX) ? (miss_count_reg + 10'd1) : miss_count_reg;

    assign q_wr.push   = accept && crossing && match && measuring_reg;
    assign q_wr.period = timestamp - start_time_reg;

    always_comb
    begin
        last_sample_next = last_sample_reg;
        peak_slope_next  = peak_slope_reg;
        miss_count_next  = miss_count_reg;
        measuring_next   = measuring_reg;
        start_time_next  = start_time_reg;
        if (accept)
        begin
            last_sample_next = sample;
            if (crossing)
            begin
                if (match)
                begin
                    if (measuring_reg)
                    begin
                        measuring_next = 1'b0;
                    end
                    else
                    begin
                        start_time_next = timestamp;
                        measuring_next  = 1'b1;
                    end
                end
                else if (slope > peak_slope_reg)
                begin
                    peak_slope_next = slope;
                    miss_count_next = '0;
                end
                else if (miss_inc > cfg.miss_limit)
                begin
                    miss_count_next = '0;
                    peak_slope_next = '0;
                end
                else
                begin
                    miss_count_next = miss_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= '0;
            peak_slope_reg  <= '0;
            miss_count_reg  <= '0;
            measuring_reg   <= 1'b1;
            start_time_reg  <= '0;
        end
        else
        begin
            last_sample_reg <= last_sample_next;
            peak_slope_reg  <= peak_slope_next;
            miss_count_reg  <= miss_count_next;
            measuring_reg   <= measuring_next;
            start_time_reg  <= start_time_next;
        end
    end

endmodule

// ===== hdl/scmpm_queue.sv =====
// Two-entry period queue between front and back end.
// Depends on scmpm_pkg.
module scmpm_queue
    import scmpm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  queue_wr_t q_wr,
    input  logic      pop,
    output logic      full,
    output queue_rd_t q_rd
);

    logic [TIME_BITS-1:0] entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]        count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full        = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign q_rd.valid  = (count_reg != '0);
    assign q_rd.period = entry_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !full;
    assign do_pop  = pop && q_rd.valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/scmpm_back.sv =====
// Back end: radix-2 restoring divider for tick_rate*2^FRAC_BITS / period,
// with saturation and the result output register. Depends on scmpm_pkg.
module scmpm_back
    import scmpm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  queue_rd_t            q_rd,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TIME_BITS-1:0] period_ticks,
    output logic [FREQ_BITS-1:0] frequency_q4
);

    localparam int NW    = RATE_BITS + FRAC_BITS;
    localparam int CNT_W = $clog2(NW + 1);
    localparam int CW    = (NW > FREQ_BITS) ? NW : FREQ_BITS;

    back_state_t state_reg, state_next;

    logic [NW-1:0]        num_reg, num_next;
    logic [NW-1:0]        quo_reg, quo_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] div_reg, div_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0] period_out_reg;
    logic [FREQ_BITS-1:0] freq_out_reg;

    logic                 start;
    logic                 step;
    logic                 load;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   sub;
    logic                 ge;
    logic [CW-1:0]        q_ext;
    logic                 sat;
    logic [FREQ_BITS-1:0] freq_val;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_rd.valid)
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        start = 1'b0;
        step  = 1'b0;
        load  = 1'b0;
        case (state_reg)
            BK_IDLE: start = q_rd.valid;
            BK_DIV:  step  = 1'b1;
            BK_LOAD: load  = !out_valid_reg || out_ready;
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    assign pop = start;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign sub   = trial - {1'b0, div_reg};
    assign ge    = !sub[TIME_BITS];

    assign q_ext    = CW'(quo_reg);
    assign sat      = (div_reg == '0) || (q_ext > CW'(FREQ_MAX));
    assign freq_val = sat ? FREQ_MAX : q_ext[FREQ_BITS-1:0];

    always_comb
    begin
        num_next = num_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            num_next = NW'(cfg.tick_rate) << FRAC_BITS;
            quo_next = '0;
            rem_next = '0;
            div_next = q_rd.period;
            cnt_next = CNT_W'(NW);
        end
        else if (step)
        begin
            num_next = num_reg << 1;
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        if (load)
        begin
            period_out_reg <= div_reg;
            freq_out_reg   <= freq_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign period_ticks = period_out_reg;
    assign frequency_q4 = freq_out_reg;

endmodule

// ===== hdl/slope_matched_crossing_pitch_meter_unit.sv =====
// Result path: a stopping crossing's period goes through the period queue and the serial divider
//   into the output register; the serial divider produces one quotient bit per cycle.
// Throughput: one sample per cycle while the two-entry period queue has room; the divider
//   takes a new period from the queue only once the last one is loaded into the output register.
// Reset (rst_n low, async): registers to defaults, measurement armed, queue and output empty.
// Top level: config registers, front end, period queue, divider back end. Uses scmpm_pkg.
module slope_matched_crossing_pitch_meter_unit
    import scmpm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [SAMPLE_BITS-1:0]  sample,
    input  logic [TIME_BITS-1:0]    timestamp,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [TIME_BITS-1:0]    period_ticks,
    output logic [FREQ_BITS-1:0]    frequency_q4
);

    cfg_t      cfg_reg, cfg_next;
    queue_wr_t q_wr;
    queue_rd_t q_rd;
    logic      q_full;
    logic      q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIDPOINT:  cfg_next.midpoint_level  = cfg_wdata[SAMPLE_BITS-1:0];
                REG_TOLERANCE: cfg_next.slope_tolerance = cfg_wdata[SAMPLE_BITS-1:0];
                REG_MISS_LIM:  cfg_next.miss_limit      = cfg_wdata[MISS_BITS-1:0];
                REG_TICK_RATE: cfg_next.tick_rate       = cfg_wdata[RATE_BITS-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midpoint_level  <= MIDPOINT_RST;
            cfg_reg.slope_tolerance <= TOLERANCE_RST;
            cfg_reg.miss_limit      <= MISS_LIM_RST;
            cfg_reg.tick_rate       <= TICK_RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scmpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .timestamp (timestamp),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    scmpm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (q_pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    scmpm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_rd         (q_rd),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .period_ticks (period_ticks),
        .frequency_q4 (frequency_q4)
    );

endmodule

// ===== hdl/scmpm_checker.sv =====
// Port-level checker for the pitch meter, bound to the top level.
// Depends on scmpm_pkg and slope_matched_crossing_pitch_meter_unit.
module scmpm_checker
    import scmpm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [TIME_BITS-1:0]    period_ticks,
    input logic [FREQ_BITS-1:0]    frequency_q4
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(period_ticks) && $stable(frequency_q4))
        else $error("result changed while stalled");

    // zero period saturates the frequency
    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (period_ticks == '0) |-> (frequency_q4 == FREQ_MAX))
        else $error("zero period not saturated");

    // queue only fills on an accepted item
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("in_ready dropped without an accepted item");

endmodule

bind slope_matched_crossing_pitch_meter_unit scmpm_checker u_scmpm_checker (.*);

// ===== tb/sv/tb_slope_matched_crossing_pitch_meter_unit.sv =====
// Self-checking bench for slope_matched_crossing_pitch_meter_unit: queue-fed driver and
// clocked monitor, with a behavioral pitch tracker predicting each period reading.
// Depends on scmpm_pkg and the unit RTL.
module tb_slope_matched_crossing_pitch_meter_unit;
    import scmpm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 600;
    localparam int FLOOD_CROSSINGS = 60;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smp;
        logic [TIME_BITS-1:0]   ts;
    } sample_item_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] period;
        logic [FREQ_BITS-1:0] freq;
    } reading_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [SAMPLE_BITS-1:0]  sample = '0;
    logic [TIME_BITS-1:0]    timestamp = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [TIME_BITS-1:0]    period_ticks;
    logic [FREQ_BITS-1:0]    frequency_q4;

    slope_matched_crossing_pitch_meter_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .timestamp    (timestamp),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .period_ticks (period_ticks),
        .frequency_q4 (frequency_q4)
    );

    always #2 clk = ~clk;

    // tracker copy of the registers and state
    logic [SAMPLE_BITS-1:0] cf_mid = MIDPOINT_RST;
    logic [SAMPLE_BITS-1:0] cf_tol = TOLERANCE_RST;
    logic [MISS_BITS-1:0]   cf_lim = MISS_LIM_RST;
    logic [RATE_BITS-1:0]   cf_rate = TICK_RATE_RST;
    logic [SAMPLE_BITS-1:0] trk_last = '0;
    logic [SAMPLE_BITS-1:0] trk_peak = '0;
    logic [MISS_BITS-1:0]   trk_miss = '0;
    logic                   trk_armed = 1'b1;
    logic [TIME_BITS-1:0]   trk_start = '0;

    sample_item_t pending_samples[$];
    reading_t     expected_readings[$];

    int idle_mode = 0;
    int fault_count = 0;
    int samples_taken = 0;
    int readings_checked = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int tone_slope = 40;
    logic [TIME_BITS-1:0] now_ticks = '0;

    task automatic log_fault(input string msg);
        if (fault_count < 100)
            $display("MISMATCH: %s", msg);
        fault_count++;
    endtask

    function automatic logic [FREQ_BITS-1:0] q4_rate(input logic [TIME_BITS-1:0] ticks);
        logic [63:0] quot;
        if (ticks == '0)
            return FREQ_MAX;
        quot = (64'(cf_rate) << FRAC_BITS_DEF) / 64'(ticks);
        if (quot > 64'(FREQ_MAX))
            return FREQ_MAX;
        return quot[FREQ_BITS-1:0];
    endfunction

    task automatic track_sample(input logic [SAMPLE_BITS-1:0] smp,
                                input logic [TIME_BITS-1:0] ts);
        logic [SAMPLE_BITS-1:0] prev;
        logic [SAMPLE_BITS-1:0] slope;
        logic [SAMPLE_BITS-1:0] gap;
        reading_t r;
        prev = trk_last;
        trk_last = smp;
        if (!(prev < cf_mid && smp >= cf_mid))
            return;
        slope = smp - prev;
        gap = (slope >= trk_peak) ? slope - trk_peak : trk_peak - slope;
        if (gap < cf_tol)
        begin
            if (trk_armed)
            begin
                trk_armed = 1'b0;
                r.period = ts - trk_start;
                r.freq = q4_rate(r.period);
                expected_readings.push_back(r);
            end
            else
            begin
                trk_start = ts;
                trk_armed = 1'b1;
            end
        end
        else if (slope > trk_peak)
        begin
            trk_peak = slope;
            trk_miss = '0;
        end
        else
        begin
            if (trk_miss != MISS_MAX)
                trk_miss++;
            if (trk_miss > cf_lim)
            begin
                trk_miss = '0;
                trk_peak = '0;
            end
        end
    endtask

    function automatic bit sender_pauses();
        case (idle_mode)
            0: return $urandom_range(99) < 28;
            1: return $urandom_range(99) < 77;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pauses();
        case (idle_mode)
            0: return $urandom_range(99) < 77;
            1: return $urandom_range(99) < 28;
            default: return 1'b0;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample <= '0;
            timestamp <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_sample(sample, timestamp);
                samples_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 && !sender_pauses())
                begin
                    it = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    sample <= it.smp;
                    timestamp <= it.ts;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        reading_t r;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                    log_fault($sformatf("unexpected item period=%0d freq=%0d",
                                        period_ticks, frequency_q4));
                else
                begin
                    r = expected_readings.pop_front();
                    readings_checked++;
                    if (period_ticks !== r.period)
                        log_fault($sformatf("period_ticks got %0d want %0d",
                                            period_ticks, r.period));
                    if (frequency_q4 !== r.freq)
                        log_fault($sformatf("frequency_q4 got %0d want %0d (period %0d)",
                                            frequency_q4, r.freq, r.period));
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (hold_arm && !hold_done)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= !receiver_pauses();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings still due",
                     cycle_count, expected_readings.size());
            $display("tb_slope_matched_crossing_pitch_meter_unit: done, errors");
            $finish;
        end
    end

    task automatic put_item(input int smp, input logic [TIME_BITS-1:0] ts);
        sample_item_t it;
        it.smp = smp[SAMPLE_BITS-1:0];
        it.ts = ts;
        pending_samples.push_back(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_MIDPOINT:  cf_mid = data[SAMPLE_BITS-1:0];
            REG_TOLERANCE: cf_tol = data[SAMPLE_BITS-1:0];
            REG_MISS_LIM:  cf_lim = data[MISS_BITS-1:0];
            REG_TICK_RATE: cf_rate = data[RATE_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [CFG_BITS-1:0] mid, input logic [CFG_BITS-1:0] tol,
                            input logic [CFG_BITS-1:0] lim, input logic [CFG_BITS-1:0] rate);
        write_reg(REG_MIDPOINT, mid);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_MISS_LIM, lim);
        write_reg(REG_TICK_RATE, rate);
        @(negedge clk);
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [TIME_BITS-1:0] pick_period();
        case ($urandom_range(9))
            0: return '0;
            1: return $urandom;
            2, 3: return $urandom_range(100000, 1000);
            default: return $urandom_range(200, 1);
        endcase
    endfunction

    // repeated crossings of one slope, now and then off by one, the shape a steady tone produces
    task automatic play_tone(output int made);
        int reps;
        int s;
        int lo;
        int hi;
        int low;
        logic [TIME_BITS-1:0] step;
        made = 0;
        if ($urandom_range(99) < 30)
            tone_slope = $urandom_range(255, 1);
        reps = $urandom_range(8, 2);
        step = pick_period();
        if ($urandom_range(19) == 0)
            now_ticks = $urandom;
        for (int k = 0; k < reps; k++)
        begin
            s = tone_slope;
            if ($urandom_range(9) == 0)
                s = s + $urandom_range(2) - 1;
            if (s < 1)
                s = 1;
            if (s > 255)
                s = 255;
            lo = (int'(cf_mid) > s) ? int'(cf_mid) - s : 0;
            hi = (int'(cf_mid) - 1 < 255 - s) ? int'(cf_mid) - 1 : 255 - s;
            low = $urandom_range(hi, lo);
            if ($urandom_range(3) == 0)
            begin
                put_item($urandom_range(255, cf_mid), now_ticks);
                made++;
            end
            put_item(low, now_ticks);
            now_ticks = now_ticks + step;
            if ($urandom_range(4) == 0)
                now_ticks = now_ticks + $urandom_range(3);
            put_item(low + s, now_ticks);
            made += 2;
        end
    endtask

    task automatic play_random(input int n);
        int made;
        int got;
        int pick;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(99);
            if (pick < 70 && cf_mid != '0)
            begin
                play_tone(got);
                made += got;
            end
            else if (pick < 85 || cf_mid == '0)
            begin
                put_item($urandom_range(255), $urandom);
                made++;
            end
            else
            begin
                // crossing of random steepness
                put_item($urandom_range(cf_mid - 1, 0), $urandom);
                put_item($urandom_range(255, cf_mid), $urandom);
                made += 2;
            end
        end
    endtask

    task automatic play_directed();
        put_item(0, 0);
        put_item(255, 0);
        put_item(0, 5);
        put_item(255, 32'hFFFF_FFFF);
        put_item(0, 10);
        put_item(255, 100);
        put_item(0, 20);
        put_item(255, 100);
        put_item(0, 1);
        put_item(255, 50);
        put_item(3, 2);
        put_item(255, 49);
        put_item(1, 3);
        put_item(255, 49);
        put_item(126, 0);
        put_item(127, 7);
        put_item(200, 0);
        put_item(255, 0);
        put_item(128, 32'hAAAA_5555);
        put_item(0, 32'h5555_AAAA);
    endtask

    // steep edge sets the peak, then a run of shallow crossings that all miss
    task automatic play_miss_flood();
        put_item(0, now_ticks);
        put_item(255, now_ticks);
        for (int k = 0; k < FLOOD_CROSSINGS; k++)
        begin
            put_item(0, now_ticks);
            put_item(cf_mid, now_ticks);
        end
        put_item(0, now_ticks);
        put_item(255, now_ticks + 777);
        put_item(0, now_ticks);
        put_item(255, now_ticks + 1554);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_mode = 0;
        play_directed();
        play_random(200);
        settle();
        set_regs(27'h7FF_FFFF, 27'd255, 27'd0, 27'd100000000);
        play_random(150);
        settle();

        idle_mode = 1;
        set_regs(27'd1, 27'd0, 27'd7, 27'd1);
        play_random(100);
        settle();
        set_regs(27'd0, 27'd1, 27'd1023, 27'd0);
        play_random(40);
        settle();
        set_regs(27'd128, 27'd2, 27'd20, 27'd0);
        play_random(200);
        settle();

        idle_mode = 2;
        set_regs(27'd64, 27'd6, 27'd1023, 27'h7FF_FFFF);
        hold_arm = 1'b1;
        play_random(150);
        play_miss_flood();
        settle();
        set_regs(27'd200, 27'd4, 27'd3, 27'd16000000);
        play_random(200);
        settle();

        $display("covered %0d samples and %0d period readings over seven register settings,",
                 samples_taken, readings_checked);
        $display("including register extremes, a run of misses and a long output stall");
        if (fault_count == 0)
            $display("tb_slope_matched_crossing_pitch_meter_unit: done, clean");
        else
            $display("tb_slope_matched_crossing_pitch_meter_unit: done, errors");
        $finish;
    end

endmodule
